/* hdl/square_ring_perimeter_walker_macros.svh */
// Assertion macros used by the ring walker emit stage.
`ifndef SQUARE_RING_PERIMETER_WALKER_MACROS_SVH
`define SQUARE_RING_PERIMETER_WALKER_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define SRPW_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define SRPW_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hdl/srpw_pkg.sv */
// Package: shared types, widths and register indexes of the ring walker.
package srpw_pkg;

    localparam int RAD_W   = 4;   // ring_radius register width
    localparam int SIDE_W  = 13;  // grid_rows / grid_cols register width
    localparam int POS_W   = 12;  // coordinate port width
    localparam int COORD_W = 14;  // signed working coordinate, covers -8..4103
    localparam int IDX_W   = 2;

    localparam int DEF_MAX_RADIUS    = 8;
    localparam int DEF_MAX_GRID_SIDE = 4096;

    localparam logic [IDX_W-1:0] REG_RING_RADIUS = 2'd0;
    localparam logic [IDX_W-1:0] REG_GRID_ROWS   = 2'd1;
    localparam logic [IDX_W-1:0] REG_GRID_COLS   = 2'd2;

    localparam logic [RAD_W-1:0]  RESET_RADIUS = 4'd1;
    localparam logic [SIDE_W-1:0] RESET_SIDE   = 13'd4096;

    typedef enum logic [3:0] {
        W_IDLE,
        W_ROW0,
        W_COL0,
        W_CENTER,
        W_TOP,
        W_RIGHT,
        W_BOTTOM,
        W_LEFT,
        W_DONE
    } srpw_state_t;

    // walker -> emitter
    typedef struct packed {
        logic                      cand_vld;
        logic signed [COORD_W-1:0] row;
        logic signed [COORD_W-1:0] col;
        logic                      fin;
    } srpw_walk_t;

    // emitter -> walker
    typedef struct packed {
        logic adv;
        logic fin_ack;
    } srpw_emit_t;

endpackage

/* hdl/square_ring_perimeter_walker.sv */
// Top level of the square ring perimeter walker.
// Usage:
//   Config: write ring_radius (index 0), grid_rows (1), grid_cols (2) with wr_en,
//   wr_index, wr_data while the block is idle. Radius (low 4 bits of wr_data) above
//   MAX_RADIUS and sides above MAX_GRID_SIDE saturate.
//   Input: one center per center_valid/center_ready transfer. center_ready is high
//   only while no ring is in progress.
//   Output: ring cells inside the grid, clockwise from the top-left corner, one per
//   cell_valid/cell_ready transfer; last_cell marks the final one. A ring wholly
//   outside the grid gives nothing. Radius zero gives the center once.
//   Timing: after the input transfer the sequencer passes setup states W_ROW0 and
//   W_COL0, then steps one ring position per cycle while the emitter advances
//   (8*radius positions, or 1 at radius zero), then ends in W_DONE. center_ready
//   stays low until the ring is finished, so a new center waits for it; the single
//   coordinate adder serves every step.
//   Stall: one cell is held back to resolve last_cell and one sits in the output
//   register; when cell_ready stays low the walk halts on the next inside cell.
//   Reset: rst_n clears the walk and output valid; registers return to radius 1,
//   4096 rows, 4096 columns.
module square_ring_perimeter_walker #(
    parameter int MAX_RADIUS    = srpw_pkg::DEF_MAX_RADIUS,
    parameter int MAX_GRID_SIDE = srpw_pkg::DEF_MAX_GRID_SIDE
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            wr_en,
    input  logic [srpw_pkg::IDX_W-1:0]      wr_index,
    input  logic [srpw_pkg::SIDE_W-1:0]     wr_data,
    input  logic                            center_valid,
    output logic                            center_ready,
    input  logic [srpw_pkg::POS_W-1:0]      center_row,
    input  logic [srpw_pkg::POS_W-1:0]      center_col,
    output logic                            cell_valid,
    input  logic                            cell_ready,
    output logic [srpw_pkg::POS_W-1:0]      cell_row,
    output logic [srpw_pkg::POS_W-1:0]      cell_col,
    output logic                            last_cell
);

    localparam int CAP_W = $clog2(MAX_GRID_SIDE + 1);
    localparam int LIM_W = (CAP_W > srpw_pkg::SIDE_W) ? CAP_W : srpw_pkg::SIDE_W;

    logic [srpw_pkg::RAD_W-1:0]  radius_reg, radius_next;
    logic [srpw_pkg::SIDE_W-1:0] rows_reg, rows_next;
    logic [srpw_pkg::SIDE_W-1:0] cols_reg, cols_next;
    logic [LIM_W-1:0]            rows_lim, cols_lim;

    srpw_pkg::srpw_walk_t walk;
    srpw_pkg::srpw_emit_t emit;

    always_comb
    begin
        radius_next = radius_reg;
        rows_next   = rows_reg;
        cols_next   = cols_reg;
        if (wr_en)
        begin
            unique case (wr_index)
                srpw_pkg::REG_RING_RADIUS: radius_next = wr_data[srpw_pkg::RAD_W-1:0];
                srpw_pkg::REG_GRID_ROWS:   rows_next   = wr_data;
                srpw_pkg::REG_GRID_COLS:   cols_next   = wr_data;
                default:                   radius_next = radius_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radius_reg <= srpw_pkg::RESET_RADIUS;
            rows_reg   <= srpw_pkg::RESET_SIDE;
            cols_reg   <= srpw_pkg::RESET_SIDE;
        end
        else
        begin
            radius_reg <= radius_next;
            rows_reg   <= rows_next;
            cols_reg   <= cols_next;
        end
    end

    assign rows_lim = (LIM_W'(rows_reg) > LIM_W'(MAX_GRID_SIDE))
                      ? LIM_W'(MAX_GRID_SIDE) : LIM_W'(rows_reg);
    assign cols_lim = (LIM_W'(cols_reg) > LIM_W'(MAX_GRID_SIDE))
                      ? LIM_W'(MAX_GRID_SIDE) : LIM_W'(cols_reg);

    srpw_walk #(
        .MAX_RADIUS (MAX_RADIUS)
    ) u_walk (
        .clk          (clk),
        .rst_n        (rst_n),
        .center_valid (center_valid),
        .center_ready (center_ready),
        .center_row   (center_row),
        .center_col   (center_col),
        .radius       (radius_reg),
        .emit         (emit),
        .walk         (walk)
    );

    srpw_emit #(
        .LIM_W (LIM_W)
    ) u_emit (
        .clk        (clk),
        .rst_n      (rst_n),
        .walk       (walk),
        .emit       (emit),
        .rows_lim   (rows_lim),
        .cols_lim   (cols_lim),
        .cell_valid (cell_valid),
        .cell_ready (cell_ready),
        .cell_row   (cell_row),
        .cell_col   (cell_col),
        .last_cell  (last_cell)
    );

endmodule

/* hdl/srpw_walk.sv */
// Ring sequencer: one shared adder steps the ring a coordinate a cycle on emit.adv.
module srpw_walk #(
    parameter int MAX_RADIUS = srpw_pkg::DEF_MAX_RADIUS
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           center_valid,
    output logic                           center_ready,
    input  logic [srpw_pkg::POS_W-1:0]     center_row,
    input  logic [srpw_pkg::POS_W-1:0]     center_col,
    input  logic [srpw_pkg::RAD_W-1:0]     radius,
    input  srpw_pkg::srpw_emit_t           emit,
    output srpw_pkg::srpw_walk_t           walk
);

    localparam int CNT_W = (2 * MAX_RADIUS > 1) ? $clog2(2 * MAX_RADIUS) : 1;
    localparam int CW    = srpw_pkg::COORD_W;

    srpw_pkg::srpw_state_t state_reg, state_next;

    logic signed [CW-1:0]             row_reg, row_next;
    logic signed [CW-1:0]             col_reg, col_next;
    logic [srpw_pkg::RAD_W-1:0]       k_reg, k_next;
    logic [CNT_W-1:0]                 cnt_reg, cnt_next;

    logic                             accept;
    logic                             side_last;
    logic [CNT_W-1:0]                 side_end;
    logic signed [CW-1:0]             add_a, add_b, add_sum;

    assign accept    = center_valid && center_ready;
    // each side covers 2k cells, corner first
    assign side_end  = CNT_W'(({1'b0, k_reg} << 1) - 5'd1);
    assign side_last = (cnt_reg == side_end);

    // the one adder every step goes through
    assign add_sum = add_a + add_b;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            srpw_pkg::W_IDLE:
                if (center_valid) state_next = srpw_pkg::W_ROW0;
            srpw_pkg::W_ROW0:
                state_next = srpw_pkg::W_COL0;
            srpw_pkg::W_COL0:
                state_next = (k_reg == '0) ? srpw_pkg::W_CENTER : srpw_pkg::W_TOP;
            srpw_pkg::W_CENTER:
                if (emit.adv) state_next = srpw_pkg::W_DONE;
            srpw_pkg::W_TOP:
                if (emit.adv && side_last) state_next = srpw_pkg::W_RIGHT;
            srpw_pkg::W_RIGHT:
                if (emit.adv && side_last) state_next = srpw_pkg::W_BOTTOM;
            srpw_pkg::W_BOTTOM:
                if (emit.adv && side_last) state_next = srpw_pkg::W_LEFT;
            srpw_pkg::W_LEFT:
                if (emit.adv && side_last) state_next = srpw_pkg::W_DONE;
            srpw_pkg::W_DONE:
                if (emit.fin_ack) state_next = srpw_pkg::W_IDLE;
            default:
                state_next = srpw_pkg::W_IDLE;
        endcase
    end

    always_comb
    begin
        center_ready  = 1'b0;
        walk.cand_vld = 1'b0;
        walk.fin      = 1'b0;
        walk.row      = row_reg;
        walk.col      = col_reg;
        add_a         = row_reg;
        add_b         = CW'(1);
        unique case (state_reg) inside
            srpw_pkg::W_IDLE:
                center_ready = 1'b1;
            srpw_pkg::W_ROW0:
            begin
                add_a = row_reg;
                add_b = -CW'(k_reg);
            end
            srpw_pkg::W_COL0:
            begin
                add_a = col_reg;
                add_b = -CW'(k_reg);
            end
            srpw_pkg::W_CENTER:
                walk.cand_vld = 1'b1;
            srpw_pkg::W_TOP:
            begin
                walk.cand_vld = 1'b1;
                add_a         = col_reg;
                add_b         = CW'(1);
            end
            srpw_pkg::W_RIGHT:
            begin
                walk.cand_vld = 1'b1;
                add_a         = row_reg;
                add_b         = CW'(1);
            end
            srpw_pkg::W_BOTTOM:
            begin
                walk.cand_vld = 1'b1;
                add_a         = col_reg;
                add_b         = -CW'(1);
            end
            srpw_pkg::W_LEFT:
            begin
                walk.cand_vld = 1'b1;
                add_a         = row_reg;
                add_b         = -CW'(1);
            end
            srpw_pkg::W_DONE:
                walk.fin = 1'b1;
            default:
                center_ready = 1'b0;
        endcase
    end

    always_comb
    begin
        row_next = row_reg;
        col_next = col_reg;
        k_next   = k_reg;
        cnt_next = cnt_reg;
        if (accept)
        begin
            row_next = CW'(center_row);
            col_next = CW'(center_col);
            k_next   = (radius > srpw_pkg::RAD_W'(MAX_RADIUS))
                       ? srpw_pkg::RAD_W'(MAX_RADIUS) : radius;
            cnt_next = '0;
        end
        else if (state_reg == srpw_pkg::W_ROW0)
            row_next = add_sum;
        else if (state_reg == srpw_pkg::W_COL0)
            col_next = add_sum;
        else if (emit.adv && (state_reg == srpw_pkg::W_TOP || state_reg == srpw_pkg::W_BOTTOM))
        begin
            col_next = add_sum;
            cnt_next = side_last ? '0 : cnt_reg + 1'b1;
        end
        else if (emit.adv && (state_reg == srpw_pkg::W_RIGHT || state_reg == srpw_pkg::W_LEFT))
        begin
            row_next = add_sum;
            cnt_next = side_last ? '0 : cnt_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= srpw_pkg::W_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        row_reg <= row_next;
        col_reg <= col_next;
        k_reg   <= k_next;
    end

endmodule

/* hdl/srpw_emit.sv */
// Clip and emit stage: grid check, one-cell hold for last marking, output register.
`include "square_ring_perimeter_walker_macros.svh"

module srpw_emit #(
    parameter int LIM_W = srpw_pkg::SIDE_W
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  srpw_pkg::srpw_walk_t       walk,
    output srpw_pkg::srpw_emit_t       emit,
    input  logic [LIM_W-1:0]           rows_lim,
    input  logic [LIM_W-1:0]           cols_lim,
    output logic                       cell_valid,
    input  logic                       cell_ready,
    output logic [srpw_pkg::POS_W-1:0] cell_row,
    output logic [srpw_pkg::POS_W-1:0] cell_col,
    output logic                       last_cell
);

    localparam int CW = srpw_pkg::COORD_W;
    localparam int PW = srpw_pkg::POS_W;

    logic          pend_vld_reg, pend_vld_next;
    logic [PW-1:0] pend_row_reg, pend_row_next;
    logic [PW-1:0] pend_col_reg, pend_col_next;
    logic          out_vld_reg, out_vld_next;
    logic [PW-1:0] out_row_reg, out_row_next;
    logic [PW-1:0] out_col_reg, out_col_next;
    logic          out_last_reg, out_last_next;

    logic          in_grid;
    logic          out_free;
    logic          take;

    assign in_grid = !walk.row[CW-1] && !walk.col[CW-1]
                     && (LIM_W'(walk.row[CW-2:0]) < rows_lim)
                     && (LIM_W'(walk.col[CW-2:0]) < cols_lim);

    assign out_free = !out_vld_reg || cell_ready;

    // a cell outside the grid is dropped at once; an inside one needs the hold slot
    assign emit.adv     = walk.cand_vld && (!in_grid || !pend_vld_reg || out_free);
    assign emit.fin_ack = walk.fin && (!pend_vld_reg || out_free);
    assign take         = emit.adv && in_grid;

    always_comb
    begin
        pend_vld_next = pend_vld_reg;
        pend_row_next = pend_row_reg;
        pend_col_next = pend_col_reg;
        out_vld_next  = out_vld_reg && !cell_ready;
        out_row_next  = out_row_reg;
        out_col_next  = out_col_reg;
        out_last_next = out_last_reg;
        if (take)
        begin
            if (pend_vld_reg)
            begin
                out_vld_next  = 1'b1;
                out_row_next  = pend_row_reg;
                out_col_next  = pend_col_reg;
                out_last_next = 1'b0;
            end
            pend_vld_next = 1'b1;
            pend_row_next = walk.row[PW-1:0];
            pend_col_next = walk.col[PW-1:0];
        end
        else if (emit.fin_ack && pend_vld_reg)
        begin
            out_vld_next  = 1'b1;
            out_row_next  = pend_row_reg;
            out_col_next  = pend_col_reg;
            out_last_next = 1'b1;
            pend_vld_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_vld_reg <= 1'b0;
            out_vld_reg  <= 1'b0;
        end
        else
        begin
            pend_vld_reg <= pend_vld_next;
            out_vld_reg  <= out_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_row_reg <= pend_row_next;
        pend_col_reg <= pend_col_next;
        out_row_reg  <= out_row_next;
        out_col_reg  <= out_col_next;
        out_last_reg <= out_last_next;
    end

    assign cell_valid = out_vld_reg;
    assign cell_row   = out_row_reg;
    assign cell_col   = out_col_reg;
    assign last_cell  = out_last_reg;

    `SRPW_ASSERT_NEXT(a_fin_clears_hold, emit.fin_ack, !pend_vld_reg,
        "hold slot still full after ring finish")
    `SRPW_ASSERT_NEXT(a_push_not_last, take && pend_vld_reg, out_vld_reg && !out_last_reg,
        "displaced cell not shown as a non-final transfer")
    `SRPW_ASSERT_NEXT(a_flush_is_last, emit.fin_ack && pend_vld_reg, out_vld_reg && out_last_reg,
        "final cell not flagged last")
    `SRPW_ASSERT_NOW(a_no_overrun, (take && pend_vld_reg) || (emit.fin_ack && pend_vld_reg),
        out_free, "output register overwritten before transfer")

endmodule
